// File: rtl/core/fdbb_pkg.sv
// Shared constants, register indexes and arithmetic helpers for the frame decimate box blur.
`default_nettype none

package fdbb_pkg;

  // Default source limits.
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // Register file layout.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_WIDTH_KEEP    = 3'd2,
    CFG_HEIGHT_KEEP   = 3'd3,
    CFG_BLUR_ENABLE   = 3'd4
  } cfg_index_t;

  // Register reset values.
  localparam logic [10:0] SOURCE_WIDTH_RST  = 11'd352;
  localparam logic [10:0] SOURCE_HEIGHT_RST = 11'd288;
  localparam logic [3:0]  KEEP_RST          = 4'd10;

  // Keep pattern repeats every ten source columns or rows.
  localparam logic [3:0] KEEP_PERIOD = 4'd10;
  localparam logic [3:0] PHASE_LAST  = 4'd9;

  // floor(x/10) = (x * 52429) >> 19 holds for x below 43690.
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  // floor(x/9) = (x * 3641) >> 15 holds for x below 32768.
  localparam logic [11:0] DIV9_MUL   = 12'd3641;
  localparam int unsigned DIV9_SHIFT = 15;

  // Cycles needed to recompute the scaled frame size after a register write.
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  function automatic logic [7:0] div9(input logic [11:0] s);
    logic [23:0] p;
    p = 24'(s) * 24'(DIV9_MUL);
    return 8'(p >> DIV9_SHIFT);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fdbb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fdbb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/frame_decimate_box_blur.sv
// Top level: pixel-drop scaler with an optional 3x3 box blur over a two-row line store.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   in       | in_valid/in_ready, pix_red/green/blue    | into block
//   out      | out_valid/out_ready, out_* , run_last    | out of block
//   cfg      | cfg_write, cfg_index, cfg_data           | into block
//
// One source pixel is taken per clock as long as each pixel yields at most one result
// and each result is taken at once; a pixel that completes two or three results holds
// the output register until each extra result is taken. The line store is one 48-bit RAM
// (two rows side by side) read and written at the scaled column, with a bypass when
// back-to-back pixels hit the same column. After reset and after each register write,
// in_ready stays low while the scaled frame size is recomputed. A stalled output backs
// up stage by stage to in_ready.
`default_nettype none

module frame_decimate_box_blur #(
  parameter int unsigned MAX_WIDTH  = fdbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fdbb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [fdbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fdbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [7:0]                    pix_red,
  input  wire logic [7:0]                    pix_green,
  input  wire logic [7:0]                    pix_blue,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [7:0]                    out_red,
  output      logic [7:0]                    out_green,
  output      logic [7:0]                    out_blue,
  output      logic [9:0]                    out_row,
  output      logic [9:0]                    out_col,
  output      logic                          run_last
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned CW1 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned RW1 = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PWW = CW1 + 4;
  localparam int unsigned PHW = RW1 + 4;

  // Configuration registers.
  logic [10:0] source_width;
  logic [10:0] source_height;
  logic [3:0]  width_keep;
  logic [3:0]  height_keep;
  logic        blur_enable;
  logic [1:0]  settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= fdbb_pkg::SOURCE_WIDTH_RST;
      source_height <= fdbb_pkg::SOURCE_HEIGHT_RST;
      width_keep    <= fdbb_pkg::KEEP_RST;
      height_keep   <= fdbb_pkg::KEEP_RST;
      blur_enable   <= 1'b0;
      settle        <= fdbb_pkg::SETTLE_CYCLES;
    end else if (cfg_write) begin
      settle <= fdbb_pkg::SETTLE_CYCLES;
      unique case (fdbb_pkg::cfg_index_t'(cfg_index))
        fdbb_pkg::CFG_SOURCE_WIDTH:  source_width  <= cfg_data;
        fdbb_pkg::CFG_SOURCE_HEIGHT: source_height <= cfg_data;
        fdbb_pkg::CFG_WIDTH_KEEP:    width_keep    <= cfg_data[3:0];
        fdbb_pkg::CFG_HEIGHT_KEEP:   height_keep   <= cfg_data[3:0];
        fdbb_pkg::CFG_BLUR_ENABLE:   blur_enable   <= cfg_data[0];
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // Saturated sizes and keep counts.
  logic [CW1-1:0] sw_c;
  logic [RW1-1:0] sh_c;
  logic [3:0]     wk_c;
  logic [3:0]     hk_c;

  always_comb begin
    if (source_width == 11'd0) begin
      sw_c = CW1'(1);
    end else if (32'(source_width) > 32'(MAX_WIDTH)) begin
      sw_c = CW1'(MAX_WIDTH);
    end else begin
      sw_c = CW1'(source_width);
    end
    if (source_height == 11'd0) begin
      sh_c = RW1'(1);
    end else if (32'(source_height) > 32'(MAX_HEIGHT)) begin
      sh_c = RW1'(MAX_HEIGHT);
    end else begin
      sh_c = RW1'(source_height);
    end
    wk_c = (width_keep > fdbb_pkg::KEEP_PERIOD) ? fdbb_pkg::KEEP_PERIOD : width_keep;
    hk_c = (height_keep > fdbb_pkg::KEEP_PERIOD) ? fdbb_pkg::KEEP_PERIOD : height_keep;
  end

  // Scaled frame size, two register stages: product, then divide by ten.
  logic [PWW-1:0] prod_w;
  logic [PHW-1:0] prod_h;
  logic [CW1-1:0] wout;
  logic [RW1-1:0] hout;
  logic [PWW+15:0] quot_w;
  logic [PHW+15:0] quot_h;

  assign quot_w = (PWW+16)'(prod_w) * (PWW+16)'(fdbb_pkg::DIV10_MUL);
  assign quot_h = (PHW+16)'(prod_h) * (PHW+16)'(fdbb_pkg::DIV10_MUL);

  always_ff @(posedge clk) begin
    prod_w <= PWW'(sw_c) * PWW'(wk_c);
    prod_h <= PHW'(sh_c) * PHW'(hk_c);
    wout   <= CW1'(quot_w >> fdbb_pkg::DIV10_SHIFT);
    hout   <= RW1'(quot_h >> fdbb_pkg::DIV10_SHIFT);
  end

  // Pipeline handshake.
  logic v1, v2;
  logic [2:0] m3;
  logic ready1, ready2, ready3;
  logic in_fire;
  logic m3_single;

  assign m3_single = (m3 == 3'b001) || (m3 == 3'b010) || (m3 == 3'b100);
  assign ready3    = (m3 == 3'b000) || (out_ready && m3_single);
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign in_ready  = (settle == 2'd0) && ready1;
  assign in_fire   = in_valid && in_ready;

  // Stage 0: position counters.
  logic [CW-1:0] src_col, scl_col;
  logic [RW-1:0] src_row, scl_row;
  logic [3:0]    col_ph, row_ph;
  logic          col_kept, row_kept, kept0;

  assign col_kept = col_ph < wk_c;
  assign row_kept = row_ph < hk_c;
  assign kept0    = col_kept && row_kept && (RW1'(scl_row) < hout) && (CW1'(scl_col) < wout);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;
      scl_col <= '0;
      src_row <= '0;
      scl_row <= '0;
      col_ph  <= '0;
      row_ph  <= '0;
    end else if (in_fire) begin
      if (CW1'(src_col) + CW1'(1) >= sw_c) begin
        src_col <= '0;
        col_ph  <= '0;
        scl_col <= '0;
        if (RW1'(src_row) + RW1'(1) >= sh_c) begin
          src_row <= '0;
          row_ph  <= '0;
          scl_row <= '0;
        end else begin
          src_row <= src_row + RW'(1);
          row_ph  <= (row_ph == fdbb_pkg::PHASE_LAST) ? 4'd0 : row_ph + 4'd1;
          if (row_kept) begin
            scl_row <= scl_row + RW'(1);
          end
        end
      end else begin
        src_col <= src_col + CW'(1);
        col_ph  <= (col_ph == fdbb_pkg::PHASE_LAST) ? 4'd0 : col_ph + 4'd1;
        if (col_kept) begin
          scl_col <= scl_col + CW'(1);
        end
      end
    end
  end

  // Line store: low half holds even scaled rows, high half odd scaled rows.
  logic          ram_we, ram_re;
  logic [47:0]   ram_wdata, ram_rdata;

  // Stage 1 registers.
  logic [23:0]   pix1;
  logic [RW-1:0] r1;
  logic [CW-1:0] c1;
  logic          kept1;
  logic          fwd1;
  logic [47:0]   fwdd1;
  logic [23:0]   win [6];

  assign ram_re = in_fire && kept0 && blur_enable;

  fdbb_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c1),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scl_col),
    .rdata (ram_rdata)
  );

  logic [47:0]       line_word;
  logic [23:0]       old_px, prev_px;
  logic [2:0][23:0]  col_new;
  logic [8:0][23:0]  nb;
  logic [11:0]       sum_r, sum_g, sum_b;
  logic              do1;
  logic [2:0]        mask1;
  logic              mean1;
  logic              r_ge1, c_ge1, c_last, r_last;

  always_comb begin
    line_word  = fwd1 ? fwdd1 : ram_rdata;
    old_px     = r1[0] ? line_word[47:24] : line_word[23:0];
    prev_px    = r1[0] ? line_word[23:0]  : line_word[47:24];
    col_new[0] = old_px;
    col_new[1] = prev_px;
    col_new[2] = pix1;
    ram_wdata  = r1[0] ? {pix1, prev_px} : {prev_px, pix1};
    do1        = v1 && kept1 && blur_enable;
    ram_we     = do1 && ready2;

    for (int i = 0; i < 3; i++) begin
      nb[3*i]   = win[2*i];
      nb[3*i+1] = win[2*i+1];
      nb[3*i+2] = col_new[i];
    end
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < 9; k++) begin
      sum_r = sum_r + 12'(nb[k][23:16]);
      sum_g = sum_g + 12'(nb[k][15:8]);
      sum_b = sum_b + 12'(nb[k][7:0]);
    end

    r_ge1  = r1 != '0;
    c_ge1  = c1 != '0;
    c_last = (CW1'(c1) + CW1'(1)) == wout;
    r_last = (RW1'(r1) + RW1'(1)) == hout;
    mean1  = (r1 >= RW'(2)) && (c1 >= CW'(2));
    if (blur_enable) begin
      mask1 = {r_last, r_ge1 && c_last, r_ge1 && c_ge1} & {3{kept1}};
    end else begin
      mask1 = {kept1, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      pix1  <= {pix_red, pix_green, pix_blue};
      r1    <= scl_row;
      c1    <= scl_col;
      kept1 <= kept0;
      // The pixel leaving stage 1 writes the same column this one reads.
      fwd1  <= ram_we && (c1 == scl_col);
      fwdd1 <= ram_wdata;
    end
    if (ram_we) begin
      for (int i = 0; i < 3; i++) begin
        win[2*i]   <= win[2*i+1];
        win[2*i+1] <= col_new[i];
      end
    end
  end

  // Stage 2: channel sums and pass-through pixels.
  logic [2:0]  m2;
  logic        mean2;
  logic [11:0] sr2, sg2, sb2;
  logic [23:0] ctr2, pb2, pc2;
  logic [9:0]  row2, col2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      m2    <= mask1;
      mean2 <= mean1;
      sr2   <= sum_r;
      sg2   <= sum_g;
      sb2   <= sum_b;
      ctr2  <= win[3];
      pb2   <= prev_px;
      pc2   <= pix1;
      row2  <= 10'(r1);
      col2  <= 10'(c1);
    end
  end

  // Stage 3: output register holding up to three results of one pixel.
  logic [23:0] va3, vb3, vc3;
  logic [9:0]  row3, col3;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3 <= 3'b000;
    end else if (ready3) begin
      m3 <= v2 ? m2 : 3'b000;
    end else if (out_ready) begin
      // Drop the result just sent; the rest of this pixel's results follow.
      m3 <= m3 & (m3 - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      va3  <= mean2 ? {fdbb_pkg::div9(sr2), fdbb_pkg::div9(sg2), fdbb_pkg::div9(sb2)} : ctr2;
      vb3  <= pb2;
      vc3  <= pc2;
      row3 <= row2;
      col3 <= col2;
    end
  end

  logic [23:0] out_px;

  always_comb begin
    out_valid = m3 != 3'b000;
    run_last  = m3_single;
    priority if (m3[0]) begin
      out_px  = va3;
      out_row = row3 - 10'd1;
      out_col = col3 - 10'd1;
    end else if (m3[1]) begin
      out_px  = vb3;
      out_row = row3 - 10'd1;
      out_col = col3;
    end else begin
      out_px  = vc3;
      out_row = row3;
      out_col = col3;
    end
    out_red   = out_px[23:16];
    out_green = out_px[15:8];
    out_blue  = out_px[7:0];
  end

endmodule

`default_nettype wire

// File: rtl/core/fdbb_checker.sv
// Port-level checks for the frame decimate box blur, bound to the top level.
`default_nettype none

module fdbb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cfg_write,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic [9:0] out_row,
  input wire logic [9:0] out_col,
  input wire logic       run_last
);

  // A result beat that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_row) && $stable(out_col) && $stable(run_last))
    else $error("result beat changed while stalled");

  // Input is held off while the scaled size is recomputed after a register write.
  a_cfg_settle: assert property (@(posedge clk)
    cfg_write |=> !in_ready ##1 !in_ready)
    else $error("input taken before scaled size settled");

  // Reset empties the output register and blocks input.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not idle after reset");

  // Results of one pixel come out without gaps.
  a_run_contig: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("gap inside the results of one pixel");

endmodule

bind frame_decimate_box_blur fdbb_checker u_fdbb_checker (.*);

`default_nettype wire
